// ===== rtl/assert_macros.svh =====
// Assertion macros shared by the RTL modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check held off while reset is asserted.
`define ASSERT_RST(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that holds on every clock edge, reset included.
`define ASSERT_ANY(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/pcmh_pkg.sv =====
// Shared types, codes and widths for the pointer clamp and motion history block.
package pcmh_pkg;

    localparam int HISTORY_DEPTH = 32;
    localparam int RING_AW       = $clog2(HISTORY_DEPTH);

    localparam int LIMIT_W = 15;
    localparam int COORD_W = 16;
    localparam int TIME_W  = 32;
    localparam int COUNT_W = 7;
    localparam int ACC_W   = COORD_W + 1;
    localparam int ALU_W   = TIME_W + 2;

    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 15'd32767;

    localparam int CFG_AW      = 4;
    localparam int APB_DW      = 32;
    localparam int IN_TDATA_W  = 128;
    localparam int OUT_TDATA_W = 72;

    typedef logic [1:0] t_req_type;
    localparam t_req_type REQ_ABS   = 2'd0;
    localparam t_req_type REQ_REL   = 2'd1;
    localparam t_req_type REQ_WARP  = 2'd2;
    localparam t_req_type REQ_QUERY = 2'd3;

    typedef logic [1:0] t_kind;
    localparam t_kind KIND_MOVED = 2'd0;
    localparam t_kind KIND_SAME  = 2'd1;
    localparam t_kind KIND_ENTRY = 2'd2;
    localparam t_kind KIND_QEND  = 2'd3;

    typedef logic [1:0] t_reg_idx;
    localparam t_reg_idx REG_X_LOW  = 2'd0;
    localparam t_reg_idx REG_X_HIGH = 2'd1;
    localparam t_reg_idx REG_Y_LOW  = 2'd2;
    localparam t_reg_idx REG_Y_HIGH = 2'd3;

    typedef struct packed {
        logic [LIMIT_W-1:0] x_low;
        logic [LIMIT_W-1:0] x_high;
        logic [LIMIT_W-1:0] y_low;
        logic [LIMIT_W-1:0] y_high;
    } t_limits;

    typedef struct packed {
        t_req_type                 req_type;
        logic signed [COORD_W-1:0] coord_x;
        logic signed [COORD_W-1:0] coord_y;
        logic [TIME_W-1:0]         event_time;
        logic [TIME_W-1:0]         window_start;
        logic [TIME_W-1:0]         window_stop;
    } t_request;

    typedef struct packed {
        t_kind                     kind;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [TIME_W-1:0]         t;
        logic [COUNT_W-1:0]        count;
        logic                      last;
    } t_result;

    typedef struct packed {
        logic [TIME_W-1:0]         t;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_entry;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef struct packed {
        t_alu_op                 op;
        logic signed [ALU_W-1:0] a;
        logic signed [ALU_W-1:0] b;
    } t_alu_req;

    typedef struct packed {
        logic signed [ALU_W-1:0] sum;
        logic                    neg;
        logic                    zero;
    } t_alu_rsp;

endpackage

// ===== rtl/pcmh_alu.sv =====
// Shared add/subtract unit with sign and zero flags, used for sums and compares.
module pcmh_alu import pcmh_pkg::*; (
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic signed [ALU_W-1:0] sum;

    always_comb begin
        if (i_req.op == ALU_ADD) begin
            sum = i_req.a + i_req.b;
        end else begin
            sum = i_req.a - i_req.b;
        end
    end

    assign o_rsp.sum  = sum;
    assign o_rsp.neg  = sum[ALU_W-1];
    assign o_rsp.zero = (sum == '0);

endmodule

// ===== rtl/pcmh_cfg.sv =====
// APB register file holding the clamp box limits.
module pcmh_cfg import pcmh_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [CFG_AW-1:0] paddr,
    input  logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0] prdata,
    output logic              pready,
    output t_limits           o_limits
);

    t_limits  r_limits;
    t_reg_idx idx;
    logic     wr;

    assign idx    = paddr[CFG_AW-1:2];
    assign wr     = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limits.x_low  <= '0;
            r_limits.x_high <= LIMIT_RESET;
            r_limits.y_low  <= '0;
            r_limits.y_high <= LIMIT_RESET;
        end else if (wr) begin
            unique case (idx)
                REG_X_LOW:  r_limits.x_low  <= pwdata[LIMIT_W-1:0];
                REG_X_HIGH: r_limits.x_high <= pwdata[LIMIT_W-1:0];
                REG_Y_LOW:  r_limits.y_low  <= pwdata[LIMIT_W-1:0];
                REG_Y_HIGH: r_limits.y_high <= pwdata[LIMIT_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_X_LOW:  prdata = APB_DW'(r_limits.x_low);
            REG_X_HIGH: prdata = APB_DW'(r_limits.x_high);
            REG_Y_LOW:  prdata = APB_DW'(r_limits.y_low);
            REG_Y_HIGH: prdata = APB_DW'(r_limits.y_high);
            default:    prdata = '0;
        endcase
    end

    assign o_limits = r_limits;

endmodule

// ===== rtl/pcmh_core.sv =====
// Request sequencer: clamp steps, history ring memory and query walk.
`include "assert_macros.svh"

module pcmh_core import pcmh_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_limits  i_limits,
    input  logic     i_req_valid,
    output logic     o_req_ready,
    input  t_request i_req,
    output logic     o_emit_valid,
    input  logic     i_emit_ready,
    output t_result  o_emit
);

    typedef enum logic [15:0] {
        S_IDLE     = 16'h0001,
        S_ADD_X    = 16'h0002,
        S_LO_X     = 16'h0004,
        S_HI_X     = 16'h0008,
        S_DEC_X    = 16'h0010,
        S_ADD_Y    = 16'h0020,
        S_LO_Y     = 16'h0040,
        S_HI_Y     = 16'h0080,
        S_DEC_Y    = 16'h0100,
        S_TCMP     = 16'h0200,
        S_MOVE_OUT = 16'h0400,
        S_Q_RD     = 16'h0800,
        S_Q_STOP   = 16'h1000,
        S_Q_START  = 16'h2000,
        S_Q_EMIT   = 16'h4000,
        S_Q_END    = 16'h8000
    } t_state;

    function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] i);
        return (i == RING_AW'(HISTORY_DEPTH - 1)) ? '0 : i + 1'b1;
    endfunction

    t_state                    r_state, n_state;
    t_request                  r_req;
    logic signed [COORD_W-1:0] r_pos_x, r_pos_y, r_nx;
    logic signed [ACC_W-1:0]   r_acc;
    logic                      r_hit;
    t_kind                     r_kind;
    logic [RING_AW-1:0]        r_head, r_tail, r_idx, r_count;

    t_entry                    mem [HISTORY_DEPTH];
    t_entry                    r_rd_data;
    logic                      rd_en, wr_en;
    logic [RING_AW-1:0]        rd_addr, wr_addr;

    t_alu_req                  alu_req;
    t_alu_rsp                  alu_rsp;

    logic                      req_fire;
    logic [RING_AW-1:0]        head_prev, head_inc, tail_skip;
    logic                      ring_empty, overwrite, moved;
    logic signed [COORD_W-1:0] ny;

    pcmh_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    assign o_req_ready = (r_state == S_IDLE);
    assign req_fire    = i_req_valid && o_req_ready;
    assign head_prev   = (r_head == '0) ? RING_AW'(HISTORY_DEPTH - 1) : r_head - 1'b1;
    assign head_inc    = ring_next(r_head);
    assign tail_skip   = ring_next(head_inc);
    assign ring_empty  = (r_head == r_tail);
    assign overwrite   = !ring_empty && alu_rsp.zero;
    assign ny          = r_hit ? alu_rsp.sum[COORD_W-1:0] : r_acc[COORD_W-1:0];
    assign moved       = (r_nx != r_pos_x) || (ny != r_pos_y);

    // shared unit operand select
    always_comb begin
        alu_req.op = ALU_SUB;
        alu_req.a  = '0;
        alu_req.b  = '0;
        unique case (r_state)
            S_ADD_X: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(r_req.coord_x);
                if (r_req.req_type == REQ_REL) begin
                    alu_req.b = ALU_W'(r_pos_x);
                end
            end
            S_LO_X: begin
                alu_req.a = ALU_W'(r_acc);
                alu_req.b = ALU_W'(i_limits.x_low);
            end
            S_HI_X: begin
                alu_req.a = ALU_W'(r_acc);
                alu_req.b = ALU_W'(i_limits.x_high);
            end
            S_DEC_X: begin
                alu_req.a = ALU_W'(i_limits.x_high);
                alu_req.b = ALU_W'(1);
            end
            S_ADD_Y: begin
                alu_req.op = ALU_ADD;
                alu_req.a  = ALU_W'(r_req.coord_y);
                if (r_req.req_type == REQ_REL) begin
                    alu_req.b = ALU_W'(r_pos_y);
                end
            end
            S_LO_Y: begin
                alu_req.a = ALU_W'(r_acc);
                alu_req.b = ALU_W'(i_limits.y_low);
            end
            S_HI_Y: begin
                alu_req.a = ALU_W'(r_acc);
                alu_req.b = ALU_W'(i_limits.y_high);
            end
            S_DEC_Y: begin
                alu_req.a = ALU_W'(i_limits.y_high);
                alu_req.b = ALU_W'(1);
            end
            S_TCMP: begin
                alu_req.a = ALU_W'(r_rd_data.t);
                alu_req.b = ALU_W'(r_req.event_time);
            end
            S_Q_STOP: begin
                alu_req.a = ALU_W'(r_rd_data.t);
                alu_req.b = ALU_W'(r_req.window_stop);
            end
            S_Q_START: begin
                alu_req.a = ALU_W'(r_rd_data.t);
                alu_req.b = ALU_W'(r_req.window_start);
            end
            default: ;
        endcase
    end

    always_comb begin
        n_state      = r_state;
        rd_en        = 1'b0;
        rd_addr      = r_idx;
        wr_en        = 1'b0;
        wr_addr      = r_head;
        o_emit_valid = 1'b0;
        o_emit       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    unique case (i_req.req_type) inside
                        REQ_WARP:  n_state = S_MOVE_OUT;
                        REQ_QUERY: n_state = S_Q_RD;
                        REQ_ABS, REQ_REL: begin
                            n_state = S_ADD_X;
                            rd_en   = 1'b1;
                            rd_addr = head_prev;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_ADD_X: n_state = S_LO_X;
            S_LO_X:  n_state = S_HI_X;
            S_HI_X:  n_state = S_DEC_X;
            S_DEC_X: n_state = S_ADD_Y;
            S_ADD_Y: n_state = S_LO_Y;
            S_LO_Y:  n_state = S_HI_Y;
            S_HI_Y:  n_state = S_DEC_Y;
            S_DEC_Y: n_state = moved ? S_TCMP : S_MOVE_OUT;
            S_TCMP: begin
                wr_en   = 1'b1;
                wr_addr = overwrite ? head_prev : r_head;
                n_state = S_MOVE_OUT;
            end
            S_MOVE_OUT: begin
                o_emit_valid = 1'b1;
                o_emit.kind  = r_kind;
                o_emit.x     = r_pos_x;
                o_emit.y     = r_pos_y;
                o_emit.t     = r_req.event_time;
                o_emit.last  = 1'b1;
                if (i_emit_ready) begin
                    n_state = S_IDLE;
                end
            end
            S_Q_RD: begin
                if (r_idx == r_head) begin
                    n_state = S_Q_END;
                end else begin
                    rd_en   = 1'b1;
                    n_state = S_Q_STOP;
                end
            end
            S_Q_STOP:  n_state = alu_rsp.neg ? S_Q_START : S_Q_END;
            S_Q_START: n_state = alu_rsp.neg ? S_Q_RD : S_Q_EMIT;
            S_Q_EMIT: begin
                o_emit_valid = 1'b1;
                o_emit.kind  = KIND_ENTRY;
                o_emit.x     = r_rd_data.x;
                o_emit.y     = r_rd_data.y;
                o_emit.t     = r_rd_data.t;
                if (i_emit_ready) begin
                    n_state = S_Q_RD;
                end
            end
            S_Q_END: begin
                o_emit_valid = 1'b1;
                o_emit.kind  = KIND_QEND;
                o_emit.count = COUNT_W'(r_count);
                o_emit.last  = 1'b1;
                if (i_emit_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pos_x <= '0;
            r_pos_y <= '0;
            r_head  <= '0;
            r_tail  <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                S_IDLE: begin
                    if (req_fire) begin
                        r_req   <= i_req;
                        r_idx   <= r_tail;
                        r_count <= '0;
                        r_kind  <= KIND_SAME;
                        if (i_req.req_type == REQ_WARP) begin
                            r_pos_x <= i_req.coord_x;
                            r_pos_y <= i_req.coord_y;
                        end
                    end
                end
                S_ADD_X, S_ADD_Y: r_acc <= alu_rsp.sum[ACC_W-1:0];
                S_LO_X: begin
                    if (alu_rsp.neg) begin
                        r_acc <= ACC_W'(i_limits.x_low);
                    end
                end
                S_LO_Y: begin
                    if (alu_rsp.neg) begin
                        r_acc <= ACC_W'(i_limits.y_low);
                    end
                end
                S_HI_X, S_HI_Y: r_hit <= !alu_rsp.neg;
                S_DEC_X: r_nx <= r_hit ? alu_rsp.sum[COORD_W-1:0] : r_acc[COORD_W-1:0];
                S_DEC_Y: begin
                    if (moved) begin
                        r_pos_x <= r_nx;
                        r_pos_y <= ny;
                        r_kind  <= KIND_MOVED;
                    end
                end
                S_TCMP: begin
                    if (!overwrite) begin
                        r_head <= head_inc;
                        if (head_inc == r_tail) begin
                            r_tail <= tail_skip;
                        end
                    end
                end
                S_Q_START: begin
                    if (alu_rsp.neg) begin
                        r_idx <= ring_next(r_idx);
                    end
                end
                S_Q_EMIT: begin
                    if (i_emit_ready) begin
                        r_idx   <= ring_next(r_idx);
                        r_count <= r_count + 1'b1;
                    end
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= '{t: r_req.event_time, y: r_pos_y, x: r_pos_x};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
        end
    end

    `ASSERT_RST(a_accept_busy, i_clk, i_rst_n, req_fire |=> r_state != S_IDLE, "request accepted but sequencer idle")
    `ASSERT_RST(a_write_fill, i_clk, i_rst_n, wr_en |=> r_head != r_tail, "ring empty after a write")
    `ASSERT_RST(a_last_idle, i_clk, i_rst_n, o_emit_valid && i_emit_ready && o_emit.last |=> r_state == S_IDLE, "final result did not return to idle")
    `ASSERT_ANY(a_idle_quiet, i_clk, r_state == S_IDLE |-> !o_emit_valid, "result offered while idle")

endmodule

// ===== rtl/pointer_clamp_motion_history.sv =====
// Pointer position keeper: clamps moves to a box, keeps a motion-history ring, answers
// time-window queries. A request is taken only while the sequencer is idle, and every
// step runs through one shared 34-bit add/compare unit and one read port of the ring
// memory. A warp goes straight to its result; an absolute or relative move runs eight
// clamp steps, then a timestamp compare with ring write when the position changed, then
// one result. A query reads each entry from the oldest on, compares it with the window
// stop and start, lists it if inside, and ends with an end item; an entry at or past the
// stop ends the walk early. A new request is accepted in the cycle after the last result
// enters the output register, even while that register still waits on the downstream
// side. No clearing pass is needed.
module pointer_clamp_motion_history import pcmh_pkg::*; (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // coord_x[15:0], coord_y[31:16], event_time[63:32], window_start[95:64],
    // window_stop[127:96]
    input  logic [IN_TDATA_W-1:0]  i_s_axis_tdata,
    // req_type[1:0]
    input  logic [1:0]             i_s_axis_tuser,
    output logic                   o_m_axis_tvalid,
    input  logic                   i_m_axis_tready,
    // out_x[15:0], out_y[31:16], out_time[63:32], match_count[70:64], zero[71]
    output logic [OUT_TDATA_W-1:0] o_m_axis_tdata,
    // kind[1:0]
    output logic [1:0]             o_m_axis_tuser,
    output logic                   o_m_axis_tlast,
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [CFG_AW-1:0]      paddr,
    input  logic [APB_DW-1:0]      pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    t_limits  limits;
    t_request req;
    t_result  emit;
    logic     emit_valid;
    logic     out_free;
    logic     r_out_valid;
    t_result  r_out;

    assign req.req_type     = i_s_axis_tuser;
    assign req.coord_x      = i_s_axis_tdata[15:0];
    assign req.coord_y      = i_s_axis_tdata[31:16];
    assign req.event_time   = i_s_axis_tdata[63:32];
    assign req.window_start = i_s_axis_tdata[95:64];
    assign req.window_stop  = i_s_axis_tdata[127:96];

    pcmh_cfg u_cfg (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .o_limits (limits)
    );

    pcmh_core u_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_limits     (limits),
        .i_req_valid  (i_s_axis_tvalid),
        .o_req_ready  (o_s_axis_tready),
        .i_req        (req),
        .o_emit_valid (emit_valid),
        .i_emit_ready (out_free),
        .o_emit       (emit)
    );

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= emit_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit_valid && out_free) begin
            r_out <= emit;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {1'b0, r_out.count, r_out.t, r_out.y, r_out.x};
    assign o_m_axis_tuser  = r_out.kind;
    assign o_m_axis_tlast  = r_out.last;

endmodule
